// ----- rtl/pngunf_pkg.sv -----
// Shared types and constants for the PNG scanline unfilter.
// Filter and color mode codes, configuration indexes and the stage slot struct.
// No dependencies.
`default_nettype none

package pngunf_pkg;

  localparam int CHAN_W     = 8;
  localparam int LEFT_N     = 4;
  localparam int CFG_W      = 11;
  localparam int ROW_W      = 10;
  localparam int MAX_HEIGHT = 1024;

  typedef enum logic [2:0] {
    FILT_NONE    = 3'd0,
    FILT_SUB     = 3'd1,
    FILT_UP      = 3'd2,
    FILT_AVG     = 3'd3,
    FILT_PAETH   = 3'd4,
    FILT_UNKNOWN = 3'd5
  } filt_t;

  typedef enum logic [1:0] {
    MODE_GRAY       = 2'd0,
    MODE_RGB        = 2'd1,
    MODE_GRAY_ALPHA = 2'd2,
    MODE_RGBA       = 2'd3
  } mode_t;

  localparam logic [1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_IDX_MODE   = 2'd2;

  // One accepted byte as it sits in the reconstruction stage.
  typedef struct packed {
    logic              is_filter;
    logic              emit;
    logic [CHAN_W-1:0] data;
    logic [1:0]        lane;
    logic              last;
    logic              eoi;
    logic              use_up;
    filt_t             filt;
  } slot_t;

  function automatic logic [2:0] bytes_per_pixel(input mode_t mode);
    logic [2:0] bpp;
    case (mode)
      MODE_GRAY:       bpp = 3'd1;
      MODE_RGB:        bpp = 3'd3;
      MODE_GRAY_ALPHA: bpp = 3'd2;
      MODE_RGBA:       bpp = 3'd4;
      default:         bpp = 3'd1;
    endcase
    return bpp;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pngunf_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module pngunf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/pngunf_track.sv -----
// Position tracker: follows filter bytes, byte positions, pixel lanes and rows,
// issues the line store read and fills the reconstruction stage. Uses pngunf_pkg.
`default_nettype none

module pngunf_track #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_BYTES_PER_PIXEL = 4,
  localparam int DEPTH = MAX_WIDTH * MAX_BYTES_PER_PIXEL,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int POS_W = $clog2(DEPTH + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [pngunf_pkg::CFG_W-1:0]      cfg_width,
  input  wire logic [pngunf_pkg::CFG_W-1:0]      cfg_height,
  input  pngunf_pkg::mode_t                      cfg_mode,
  input  wire logic                              accept,
  input  wire logic [pngunf_pkg::CHAN_W-1:0]     data_byte,
  input  wire logic                              advance,
  output logic                                   rd_en,
  output logic [AW-1:0]                          rd_addr,
  output logic                                   s1_valid,
  output pngunf_pkg::slot_t                      s1_slot,
  output logic [AW-1:0]                          s1_addr
);

  logic [2:0]                    bpp_raw;
  logic [2:0]                    bpp;
  logic [pngunf_pkg::CFG_W-1:0]  w_eff;
  logic [pngunf_pkg::CFG_W-1:0]  h_eff;
  logic [13:0]                   row_len;

  logic [POS_W-1:0]              pos_r, pos_nxt;
  logic [1:0]                    lane_r, lane_nxt;
  logic [pngunf_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic                          first_r, first_nxt;
  pngunf_pkg::filt_t             filt_r, filt_nxt;
  logic                          s1_valid_r, s1_valid_nxt;
  pngunf_pkg::slot_t             s1_slot_r, s1_slot_nxt;
  logic [AW-1:0]                 s1_addr_r, s1_addr_nxt;

  logic                          is_filter;
  logic                          last;
  logic                          lane_wrap;
  logic                          eoi;
  logic [POS_W-1:0]              x_full;
  pngunf_pkg::filt_t             code;
  pngunf_pkg::slot_t             slot;

  // Effective geometry: out-of-range values are clamped.
  always_comb begin
    bpp_raw = pngunf_pkg::bytes_per_pixel(cfg_mode);
    bpp     = (32'(bpp_raw) > MAX_BYTES_PER_PIXEL) ? 3'(MAX_BYTES_PER_PIXEL) : bpp_raw;
    if (cfg_width == '0) begin
      w_eff = pngunf_pkg::CFG_W'(1);
    end else if (32'(cfg_width) > MAX_WIDTH) begin
      w_eff = pngunf_pkg::CFG_W'(MAX_WIDTH);
    end else begin
      w_eff = cfg_width;
    end
    if (cfg_height == '0) begin
      h_eff = pngunf_pkg::CFG_W'(1);
    end else if (32'(cfg_height) > pngunf_pkg::MAX_HEIGHT) begin
      h_eff = pngunf_pkg::CFG_W'(pngunf_pkg::MAX_HEIGHT);
    end else begin
      h_eff = cfg_height;
    end
    row_len = 14'(w_eff) * 14'(bpp);
  end

  always_comb begin
    is_filter = (pos_r == '0);
    last      = 32'(pos_r) >= 32'(row_len);
    lane_wrap = ({1'b0, lane_r} + 3'd1) == bpp;
    eoi       = last && (({1'b0, row_r} + pngunf_pkg::CFG_W'(1)) >= h_eff);
    x_full    = pos_r - POS_W'(1);
    rd_addr   = x_full[AW-1:0];
    rd_en     = accept && !is_filter;
    code      = (data_byte > 8'd4) ? pngunf_pkg::FILT_UNKNOWN
                                   : pngunf_pkg::filt_t'(data_byte[2:0]);

    slot.is_filter = is_filter;
    slot.emit      = !is_filter && (lane_wrap || last);
    slot.data      = data_byte;
    slot.lane      = lane_r;
    slot.last      = last;
    slot.eoi       = eoi;
    slot.use_up    = !first_r;
    slot.filt      = is_filter ? code : filt_r;
  end

  // Next position state, advanced once per accepted item.
  always_comb begin
    pos_nxt   = pos_r;
    lane_nxt  = lane_r;
    row_nxt   = row_r;
    first_nxt = first_r;
    filt_nxt  = filt_r;
    if (accept) begin
      if (is_filter) begin
        filt_nxt = code;
        pos_nxt  = POS_W'(1);
        lane_nxt = 2'd0;
      end else if (last) begin
        pos_nxt  = '0;
        lane_nxt = 2'd0;
        if (eoi) begin
          row_nxt   = '0;
          first_nxt = 1'b1;
        end else begin
          row_nxt   = row_r + pngunf_pkg::ROW_W'(1);
          first_nxt = 1'b0;
        end
      end else begin
        pos_nxt  = pos_r + POS_W'(1);
        lane_nxt = lane_wrap ? 2'd0 : lane_r + 2'd1;
      end
    end
  end

  always_comb begin
    s1_slot_nxt  = accept ? slot : s1_slot_r;
    s1_addr_nxt  = accept ? rd_addr : s1_addr_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      lane_r     <= 2'd0;
      row_r      <= '0;
      first_r    <= 1'b1;
      filt_r     <= pngunf_pkg::FILT_NONE;
      s1_valid_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      lane_r     <= lane_nxt;
      row_r      <= row_nxt;
      first_r    <= first_nxt;
      filt_r     <= filt_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_slot_r <= s1_slot_nxt;
    s1_addr_r <= s1_addr_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1_slot  = s1_slot_r;
  assign s1_addr  = s1_addr_r;

endmodule

`default_nettype wire

// ----- rtl/pngunf_recon.sv -----
// Reconstruction: undoes None, Sub, Up, Average filters, flags Paeth/unknown bad,
// keeps the left bytes, the partial pixel and the output register. Uses pngunf_pkg.
`default_nettype none

module pngunf_recon (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  pngunf_pkg::mode_t                  cfg_mode,
  input  wire logic                          s1_valid,
  input  pngunf_pkg::slot_t                  s1_slot,
  input  wire logic [pngunf_pkg::CHAN_W-1:0] up_byte,
  input  wire logic                          out_stall,
  output logic                               advance,
  output logic                               wr_en,
  output logic [pngunf_pkg::CHAN_W-1:0]      wr_data,
  output logic                               out_valid,
  output logic [pngunf_pkg::CHAN_W-1:0]      out_red,
  output logic [pngunf_pkg::CHAN_W-1:0]      out_green,
  output logic [pngunf_pkg::CHAN_W-1:0]      out_blue,
  output logic [pngunf_pkg::CHAN_W-1:0]      out_alpha,
  output logic                               out_end_of_row,
  output logic                               out_end_of_image,
  output logic                               out_bad_filter
);

  localparam int CW = pngunf_pkg::CHAN_W;

  logic [CW-1:0]   left_r   [pngunf_pkg::LEFT_N];
  logic [CW-1:0]   left_nxt [pngunf_pkg::LEFT_N];
  logic [3*CW-1:0] gather_r, gather_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [CW-1:0]   red_r, green_r, blue_r, alpha_r;
  logic [CW-1:0]   red_nxt, green_nxt, blue_nxt, alpha_nxt;
  logic            eor_r, eoi_r, bad_r;
  logic            eor_nxt, eoi_nxt, bad_nxt;

  logic [CW-1:0]   left;
  logic [CW-1:0]   up;
  logic [CW:0]     avg_sum;
  logic [CW-1:0]   recon;
  logic [CW-1:0]   chan [pngunf_pkg::LEFT_N];
  logic            out_ok;
  logic            load;

  always_comb begin
    left    = left_r[s1_slot.lane];
    up      = s1_slot.use_up ? up_byte : '0;
    avg_sum = {1'b0, left} + {1'b0, up};
    case (s1_slot.filt)
      pngunf_pkg::FILT_SUB: recon = s1_slot.data + left;
      pngunf_pkg::FILT_UP:  recon = s1_slot.data + up;
      pngunf_pkg::FILT_AVG: recon = s1_slot.data + avg_sum[CW:1];
      default:              recon = s1_slot.data;
    endcase
    wr_data = recon;
  end

  // Handshake between the stage and the output register.
  always_comb begin
    out_ok  = !out_valid_r || !out_stall;
    advance = s1_valid && (!s1_slot.emit || out_ok);
    wr_en   = advance && !s1_slot.is_filter;
    load    = advance && s1_slot.emit;
  end

  // Channel assembly; a pixel cut short at row end has zero in its missing bytes.
  always_comb begin
    chan[0] = gather_r[CW-1:0];
    chan[1] = gather_r[2*CW-1:CW];
    chan[2] = gather_r[3*CW-1:2*CW];
    chan[3] = '0;
    chan[s1_slot.lane] = recon;
    case (cfg_mode)
      pngunf_pkg::MODE_GRAY: begin
        red_nxt = chan[0]; green_nxt = chan[0]; blue_nxt = chan[0]; alpha_nxt = '1;
      end
      pngunf_pkg::MODE_RGB: begin
        red_nxt = chan[0]; green_nxt = chan[1]; blue_nxt = chan[2]; alpha_nxt = '1;
      end
      pngunf_pkg::MODE_GRAY_ALPHA: begin
        red_nxt = chan[0]; green_nxt = chan[0]; blue_nxt = chan[0]; alpha_nxt = chan[1];
      end
      default: begin
        red_nxt = chan[0]; green_nxt = chan[1]; blue_nxt = chan[2]; alpha_nxt = chan[3];
      end
    endcase
    eor_nxt = s1_slot.last;
    eoi_nxt = s1_slot.eoi;
    bad_nxt = (s1_slot.filt == pngunf_pkg::FILT_PAETH) ||
              (s1_slot.filt == pngunf_pkg::FILT_UNKNOWN);
  end

  always_comb begin
    left_nxt   = left_r;
    gather_nxt = gather_r;
    if (advance) begin
      if (s1_slot.is_filter) begin
        for (int i = 0; i < pngunf_pkg::LEFT_N; i++) begin
          left_nxt[i] = '0;
        end
        gather_nxt = '0;
      end else begin
        left_nxt[s1_slot.lane] = recon;
        if (s1_slot.emit) begin
          gather_nxt = '0;
        end else if (s1_slot.lane < 2'd3) begin
          gather_nxt[s1_slot.lane*CW +: CW] = recon;
        end
      end
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      gather_r    <= '0;
      for (int i = 0; i < pngunf_pkg::LEFT_N; i++) begin
        left_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      gather_r    <= gather_nxt;
      left_r      <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      alpha_r <= alpha_nxt;
      eor_r   <= eor_nxt;
      eoi_r   <= eoi_nxt;
      bad_r   <= bad_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_red          = red_r;
  assign out_green        = green_r;
  assign out_blue         = blue_r;
  assign out_alpha        = alpha_r;
  assign out_end_of_row   = eor_r;
  assign out_end_of_image = eoi_r;
  assign out_bad_filter   = bad_r;

endmodule

`default_nettype wire

// ----- rtl/png_scanline_unfilter.sv -----
// PNG scanline unfilter, top level: configuration registers, line store and
// the two pipeline parts. Uses pngunf_pkg, pngunf_ram, pngunf_track, pngunf_recon.
//
// Usage. The input channel (in_valid, in_stall, in_data_byte) carries the
// inflated image stream one byte per item, the filter byte of each scanline
// included. The output channel (out_valid, out_stall, out_*) carries one RGBA
// pixel per item, sent when the last byte of that pixel arrives, with
// end-of-row, end-of-image and bad-filter marks. Filter bytes give no item.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// width (index 0), height (index 1) and color mode (index 2); it is always
// ready and must only be used while the block is idle.
// Path: a taken byte is registered in the reconstruction stage, and the pixel it
// finishes is then loaded into the output register once that register is free.
// Throughput: one byte per cycle while out_stall holds no finished pixel.
// Each data byte makes one read and one write of the prior-row line store, on
// separate ports; filter bytes make neither.
// Reset (synchronous, rst_n low) returns to expecting a filter byte on the
// first row of an image; the line store is not cleared and needs no pass.
// When out_stall holds a finished pixel, bytes are still taken as long as the
// byte in the stage does not itself finish a pixel; otherwise in_stall rises.
`default_nettype none

module png_scanline_unfilter #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_BYTES_PER_PIXEL = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [pngunf_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [pngunf_pkg::CHAN_W-1:0]  in_data_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [pngunf_pkg::CHAN_W-1:0]       out_red,
  output logic [pngunf_pkg::CHAN_W-1:0]       out_green,
  output logic [pngunf_pkg::CHAN_W-1:0]       out_blue,
  output logic [pngunf_pkg::CHAN_W-1:0]       out_alpha,
  output logic                                out_end_of_row,
  output logic                                out_end_of_image,
  output logic                                out_bad_filter
);

  localparam int DEPTH = MAX_WIDTH * MAX_BYTES_PER_PIXEL;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [pngunf_pkg::CFG_W-1:0] width_r, width_nxt;
  logic [pngunf_pkg::CFG_W-1:0] height_r, height_nxt;
  pngunf_pkg::mode_t            mode_r, mode_nxt;

  logic                          accept;
  logic                          advance;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic                          s1_valid;
  pngunf_pkg::slot_t             s1_slot;
  logic [AW-1:0]                 s1_addr;
  logic                          wr_en;
  logic [pngunf_pkg::CHAN_W-1:0] wr_data;
  logic [pngunf_pkg::CHAN_W-1:0] up_byte;

  // Configuration registers; writes to an unused index are dropped.
  assign cfg_ready = 1'b1;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    mode_nxt   = mode_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pngunf_pkg::CFG_IDX_WIDTH:  width_nxt  = cfg_data;
        pngunf_pkg::CFG_IDX_HEIGHT: height_nxt = cfg_data;
        pngunf_pkg::CFG_IDX_MODE:   mode_nxt   = pngunf_pkg::mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= pngunf_pkg::CFG_W'(1);
      height_r <= pngunf_pkg::CFG_W'(1);
      mode_r   <= pngunf_pkg::MODE_GRAY;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      mode_r   <= mode_nxt;
    end
  end

  // The stage takes a new byte whenever its current one moves on this cycle.
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  pngunf_track #(
    .MAX_WIDTH           (MAX_WIDTH),
    .MAX_BYTES_PER_PIXEL (MAX_BYTES_PER_PIXEL)
  ) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .cfg_mode   (mode_r),
    .accept     (accept),
    .data_byte  (in_data_byte),
    .advance    (advance),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .s1_valid   (s1_valid),
    .s1_slot    (s1_slot),
    .s1_addr    (s1_addr)
  );

  // Prior-row line store. A read is only issued when a byte enters the
  // stage, so the read data stays put while the stage is held.
  pngunf_ram #(
    .WIDTH (pngunf_pkg::CHAN_W),
    .DEPTH (DEPTH)
  ) u_prior (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (up_byte)
  );

  pngunf_recon u_recon (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_mode         (mode_r),
    .s1_valid         (s1_valid),
    .s1_slot          (s1_slot),
    .up_byte          (up_byte),
    .out_stall        (out_stall),
    .advance          (advance),
    .wr_en            (wr_en),
    .wr_data          (wr_data),
    .out_valid        (out_valid),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_image (out_end_of_image),
    .out_bad_filter   (out_bad_filter)
  );

  // A write back and a fresh read never hit the same line store entry.
  a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (s1_addr != rd_addr))
    else $error("line store read and write collide");

  // The final pixel of the image is also the final pixel of its row.
  a_eoi_is_eor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_image) |-> out_end_of_row)
    else $error("end of image without end of row");

  // Input is only held back by a byte waiting in the stage.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid)
    else $error("input stalled with an empty stage");

  // A byte held in the stage keeps its contents.
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_slot)))
    else $error("held stage item changed");

endmodule

`default_nettype wire
